// ===== src/point_to_ray_distance_unit_assert.svh =====
// assertion macros for the point to ray distance unit
`ifndef POINT_TO_RAY_DISTANCE_UNIT_ASSERT_SVH
`define POINT_TO_RAY_DISTANCE_UNIT_ASSERT_SVH

// check on every edge, reset included
`define PTRD_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// check only outside reset
`define PTRD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

// ===== src/ptrd_pkg.sv =====
// shared types and constants of the point to ray distance unit
`default_nettype none

package ptrd_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned DIST_W  = 32;
    localparam int unsigned QUOT_W  = 2 * DIST_W;

    typedef struct packed {
        logic signed [FIELD_W-1:0] start_x;
        logic signed [FIELD_W-1:0] start_y;
        logic signed [FIELD_W-1:0] start_z;
        logic signed [FIELD_W-1:0] dir_x;
        logic signed [FIELD_W-1:0] dir_y;
        logic signed [FIELD_W-1:0] dir_z;
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
        logic signed [FIELD_W-1:0] point_z;
    } t_ray_req;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              zero_direction;
    } t_ray_res;

endpackage

`default_nettype wire

// ===== src/ptrd_cross.sv =====
// difference vector, cross product and squared direction length
`default_nettype none

module ptrd_cross import ptrd_pkg::*; #(
    parameter int W = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire t_ray_req            i_req,
    output logic                     o_valid,
    output logic signed [2*W+1:0]    o_c [3],
    output logic        [2*W:0]      o_den,
    output logic                     o_zero
);

    logic [W-1:0]         s [3];
    logic [W-1:0]         d [3];
    logic [W-1:0]         p [3];
    logic [2:0]           r_v;

    logic signed [W:0]    r_a [3];
    logic signed [W-1:0]  r_b [3];
    logic                 r_zero_a;

    logic signed [2*W:0]   r_p [6];
    logic signed [2*W-1:0] r_bb [3];
    logic                  r_zero_b;

    logic signed [2*W+1:0] r_c [3];
    logic        [2*W:0]   r_den;
    logic                  r_zero_c;

    always_comb begin
        s[0] = i_req.start_x[W-1:0];
        s[1] = i_req.start_y[W-1:0];
        s[2] = i_req.start_z[W-1:0];
        d[0] = i_req.dir_x[W-1:0];
        d[1] = i_req.dir_y[W-1:0];
        d[2] = i_req.dir_z[W-1:0];
        p[0] = i_req.point_x[W-1:0];
        p[1] = i_req.point_y[W-1:0];
        p[2] = i_req.point_z[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= {s[i][W-1], s[i]} - {p[i][W-1], p[i]};
                r_b[i] <= d[i];
            end
            r_zero_a <= (d[0] == '0) && (d[1] == '0) && (d[2] == '0);

            r_p[0] <= (2*W+1)'(r_a[1]) * (2*W+1)'(r_b[2]);
            r_p[1] <= (2*W+1)'(r_a[2]) * (2*W+1)'(r_b[1]);
            r_p[2] <= (2*W+1)'(r_a[2]) * (2*W+1)'(r_b[0]);
            r_p[3] <= (2*W+1)'(r_a[0]) * (2*W+1)'(r_b[2]);
            r_p[4] <= (2*W+1)'(r_a[0]) * (2*W+1)'(r_b[1]);
            r_p[5] <= (2*W+1)'(r_a[1]) * (2*W+1)'(r_b[0]);
            for (int i = 0; i < 3; i++) begin
                r_bb[i] <= (2*W)'(r_b[i]) * (2*W)'(r_b[i]);
            end
            r_zero_b <= r_zero_a;

            for (int i = 0; i < 3; i++) begin
                r_c[i] <= {r_p[2*i][2*W], r_p[2*i]} - {r_p[2*i+1][2*W], r_p[2*i+1]};
            end
            // squares are non-negative and their sum stays below 2^(2W)
            r_den    <= {1'b0, r_bb[0]} + {1'b0, r_bb[1]} + {1'b0, r_bb[2]};
            r_zero_c <= r_zero_b;
        end
    end

    assign o_valid = r_v[2];
    assign o_c     = r_c;
    assign o_den   = r_den;
    assign o_zero  = r_zero_c;

endmodule

`default_nettype wire

// ===== src/ptrd_square.sv =====
// squared length of the cross product from half-width partial products
`default_nettype none

module ptrd_square import ptrd_pkg::*; #(
    parameter int W = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic signed [2*W+1:0] i_c [3],
    input  wire logic        [2*W:0]   i_den,
    input  wire logic                  i_zero,
    output logic                       o_valid,
    output logic [4*W+3:0]             o_num,
    output logic [2*W:0]               o_den,
    output logic                       o_zero
);

    localparam int MW = 2 * W + 1;
    localparam int LW = (MW + 1) / 2;
    localparam int HW = MW - LW;
    localparam int NW = 2 * MW + 2;

    logic [3:0]          r_v;
    logic [2*W:0]        r_den [4];
    logic                r_zero [4];

    logic [MW-1:0]       r_m  [3];
    logic [2*HW-1:0]     r_hh [3];
    logic [HW+LW-1:0]    r_hl [3];
    logic [2*LW-1:0]     r_ll [3];
    logic [2*MW-1:0]     r_sq [3];
    logic [NW-1:0]       r_num;

    logic [MW:0]         n_neg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_neg[i] = ~i_c[i] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_zero[0] <= i_zero;
            for (int k = 1; k < 4; k++) begin
                r_den[k]  <= r_den[k-1];
                r_zero[k] <= r_zero[k-1];
            end

            for (int i = 0; i < 3; i++) begin
                // magnitude, at most 2^(2W) so MW bits hold it
                r_m[i] <= i_c[i][MW] ? n_neg[i][MW-1:0] : i_c[i][MW-1:0];

                r_hh[i] <= (2*HW)'(r_m[i][MW-1:LW]) * (2*HW)'(r_m[i][MW-1:LW]);
                r_hl[i] <= (HW+LW)'(r_m[i][MW-1:LW]) * (HW+LW)'(r_m[i][LW-1:0]);
                r_ll[i] <= (2*LW)'(r_m[i][LW-1:0]) * (2*LW)'(r_m[i][LW-1:0]);

                r_sq[i] <= ((2*MW)'(r_hh[i]) << (2*LW))
                         + ((2*MW)'(r_hl[i]) << (LW+1))
                         + (2*MW)'(r_ll[i]);
            end

            r_num <= NW'(r_sq[0]) + NW'(r_sq[1]) + NW'(r_sq[2]);
        end
    end

    assign o_valid = r_v[3];
    assign o_num   = r_num;
    assign o_den   = r_den[3];
    assign o_zero  = r_zero[3];

endmodule

`default_nettype wire

// ===== src/ptrd_div.sv =====
// restoring divider, one quotient bit per stage, with overflow detect
`default_nettype none

module ptrd_div import ptrd_pkg::*; #(
    parameter int NW = 132,
    parameter int DW = 65
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic          i_zero,
    output logic               o_valid,
    output logic [QUOT_W-1:0]  o_q,
    output logic               o_sat,
    output logic               o_zero
);

    localparam int QB = QUOT_W;
    localparam int XW = (NW > DW + QB) ? NW : DW + QB;

    logic [QB:0]       r_v;
    logic [XW-1:0]     r_rem  [QB+1];
    logic [DW-1:0]     r_dd   [QB+1];
    logic [QB-1:0]     r_q    [QB+1];
    logic              r_sat  [QB+1];
    logic              r_zero [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QB-1:0], i_valid};
        end
    end

    // quotient of 2^QB or more saturates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= XW'(i_num);
            r_dd[0]   <= i_den;
            r_q[0]    <= '0;
            r_sat[0]  <= (XW+1)'(i_num) >= ((XW+1)'(i_den) << QB);
            r_zero[0] <= i_zero;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int BIT = QB - 1 - k;
        logic [XW:0]   n_diff;
        logic [QB-1:0] n_q;

        always_comb begin
            n_diff   = {1'b0, r_rem[k]} - ((XW+1)'(r_dd[k]) << BIT);
            n_q      = r_q[k];
            n_q[BIT] = ~n_diff[XW];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_diff[XW] ? r_rem[k] : n_diff[XW-1:0];
                r_q[k+1]    <= n_q;
                r_dd[k+1]   <= r_dd[k];
                r_sat[k+1]  <= r_sat[k];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_q     = r_q[QB];
    assign o_sat   = r_sat[QB];
    assign o_zero  = r_zero[QB];

endmodule

`default_nettype wire

// ===== src/ptrd_sqrt.sv =====
// integer square root, one result bit per stage
`default_nettype none

module ptrd_sqrt import ptrd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [QUOT_W-1:0] i_q,
    input  wire logic              i_sat,
    input  wire logic              i_zero,
    output logic                   o_valid,
    output logic [DIST_W-1:0]      o_root,
    output logic                   o_sat,
    output logic                   o_zero
);

    localparam int RB = DIST_W;
    localparam int RW = QUOT_W + 2;

    logic [RB:0]       r_v;
    logic [RW-1:0]     r_rem  [RB+1];
    logic [RB-1:0]     r_root [RB+1];
    logic              r_sat  [RB+1];
    logic              r_zero [RB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RB-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= RW'(i_q);
            r_root[0] <= '0;
            r_sat[0]  <= i_sat;
            r_zero[0] <= i_zero;
        end
    end

    // remainder holds q - root^2
    for (genvar k = 0; k < RB; k++) begin : g_stage
        localparam int BIT = RB - 1 - k;
        logic [RW-1:0] n_trial;
        logic [RW:0]   n_diff;
        logic [RB-1:0] n_root;

        always_comb begin
            n_trial     = (RW'(r_root[k]) << (BIT + 1)) + (RW'(1) << (2 * BIT));
            n_diff      = {1'b0, r_rem[k]} - {1'b0, n_trial};
            n_root      = r_root[k];
            n_root[BIT] = ~n_diff[RW];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_diff[RW] ? r_rem[k] : n_diff[RW-1:0];
                r_root[k+1] <= n_root;
                r_sat[k+1]  <= r_sat[k];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    assign o_valid = r_v[RB];
    assign o_root  = r_root[RB];
    assign o_sat   = r_sat[RB];
    assign o_zero  = r_zero[RB];

endmodule

`default_nettype wire

// ===== src/point_to_ray_distance_unit.sv =====
// point to ray distance unit: |(s - p) x d| / |d| in fixed point, pipelined
// accepts one request per cycle while o_stall is low
// depth set by the 64 stage divider and 32 stage square root, one bit each
// synchronous active-low reset empties the pipeline and the output/skid registers
`default_nettype none
`include "point_to_ray_distance_unit_assert.svh"

module point_to_ray_distance_unit import ptrd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_ray_req i_req,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_ray_res      o_res
);

    // derived widths: difference W+1, cross term 2W+2, |c|^2 sum 4W+4, |d|^2 sum 2W+1
    localparam int W  = FIELD_W;
    localparam int NW = 4 * W + 4;
    localparam int DW = 2 * W + 1;

    // the whole pipeline moves together; it halts only while the skid holds a request
    logic                   adv;

    logic                   cr_valid;
    logic signed [2*W+1:0]  cr_c [3];
    logic        [DW-1:0]   cr_den;
    logic                   cr_zero;

    logic                   sq_valid;
    logic        [NW-1:0]   sq_num;
    logic        [DW-1:0]   sq_den;
    logic                   sq_zero;

    logic                   dv_valid;
    logic [QUOT_W-1:0]      dv_q;
    logic                   dv_sat;
    logic                   dv_zero;

    logic                   rt_valid;
    logic [DIST_W-1:0]      rt_root;
    logic                   rt_sat;
    logic                   rt_zero;

    t_ray_res               n_last;
    logic                   out_free;

    logic                   r_out_v;
    t_ray_res               r_out;
    logic                   r_skid_v;
    t_ray_res               r_skid;

    assign adv     = !r_skid_v;
    assign o_stall = r_skid_v;

    // stage group 1: s - p, cross product terms, |d|^2
    ptrd_cross #(.W(W)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_valid (cr_valid),
        .o_c     (cr_c),
        .o_den   (cr_den),
        .o_zero  (cr_zero)
    );

    // stage group 2: |c|^2 from split multiplies
    ptrd_square #(.W(W)) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (cr_valid),
        .i_c     (cr_c),
        .i_den   (cr_den),
        .i_zero  (cr_zero),
        .o_valid (sq_valid),
        .o_num   (sq_num),
        .o_den   (sq_den),
        .o_zero  (sq_zero)
    );

    // stage group 3: floor(|c|^2 / |d|^2), saturating beyond 64 bits
    ptrd_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (sq_valid),
        .i_num   (sq_num),
        .i_den   (sq_den),
        .i_zero  (sq_zero),
        .o_valid (dv_valid),
        .o_q     (dv_q),
        .o_sat   (dv_sat),
        .o_zero  (dv_zero)
    );

    // stage group 4: floor of the square root; floor(sqrt(floor(x))) == floor(sqrt(x))
    ptrd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (dv_valid),
        .i_q     (dv_q),
        .i_sat   (dv_sat),
        .i_zero  (dv_zero),
        .o_valid (rt_valid),
        .o_root  (rt_root),
        .o_sat   (rt_sat),
        .o_zero  (rt_zero)
    );

    // zero direction wins over saturation (a zero divisor also flags overflow)
    always_comb begin
        n_last.zero_direction = rt_zero;
        if (rt_zero) begin
            n_last.distance = '0;
        end else if (rt_sat) begin
            n_last.distance = '1;
        end else begin
            n_last.distance = rt_root;
        end
    end

    assign out_free = !r_out_v || !i_stall;

    // output register with a one-entry skid: the pipeline keeps taking requests
    // while a result waits, and halts once the skid fills
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= rt_valid;
            end
        end else if (rt_valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : n_last;
        end
        if (!out_free && !r_skid_v) begin
            r_skid <= n_last;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

    `PTRD_ASSERT_CLK(a_reset_empties, !i_rst_n |=> !o_valid && !o_stall, "reset left a request in flight")
    `PTRD_ASSERT_RST(a_skid_needs_out, r_skid_v |-> r_out_v, "skid holds a request while output is empty")
    `PTRD_ASSERT_RST(a_skid_holds, r_skid_v && i_stall |=> r_skid_v && $stable(r_skid), "skid request lost under stall")
    `PTRD_ASSERT_RST(a_zero_dir_dist, o_valid && o_res.zero_direction |-> o_res.distance == '0, "zero direction with nonzero distance")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// testbench for the point to ray distance unit with a bit-exact predictor
`timescale 1ns / 100ps

module tb;
    import ptrd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_stall = 1'b0;
    t_ray_req i_req = '0;
    logic     o_stall;
    logic     o_valid;
    t_ray_res o_res;

    t_ray_res    dist_expected[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          quiet = 1'b0; // no idling on either side while set

    point_to_ray_distance_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    always #6 i_clk = ~i_clk;

    // exact distance: largest r with r*r*|d|^2 <= |(s-p) x d|^2, saturating at 32 bits
    function automatic t_ray_res predict_distance(t_ray_req q);
        logic signed [39:0] ax, ay, az, bx, by, bz;
        logic signed [79:0] cx, cy, cz;
        logic [159:0]       cross_sq, dir_sq;
        logic [199:0]       scaled;
        logic [31:0]        root, trial;
        t_ray_res           res;
        ax = 40'(q.start_x) - 40'(q.point_x);
        ay = 40'(q.start_y) - 40'(q.point_y);
        az = 40'(q.start_z) - 40'(q.point_z);
        bx = 40'(q.dir_x);
        by = 40'(q.dir_y);
        bz = 40'(q.dir_z);
        cx = 80'(ay) * 80'(bz) - 80'(az) * 80'(by);
        cy = 80'(az) * 80'(bx) - 80'(ax) * 80'(bz);
        cz = 80'(ax) * 80'(by) - 80'(ay) * 80'(bx);
        cross_sq = 160'(cx) * 160'(cx) + 160'(cy) * 160'(cy) + 160'(cz) * 160'(cz);
        dir_sq   = 160'(bx) * 160'(bx) + 160'(by) * 160'(by) + 160'(bz) * 160'(bz);
        root = '0;
        res  = '0;
        if (dir_sq == '0) begin
            res.zero_direction = 1'b1;
            return res;
        end
        for (int b = 31; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            scaled = 200'(trial) * 200'(trial) * 200'(dir_sq);
            if (scaled <= 200'(cross_sq)) root = trial;
        end
        res.distance = root;
        return res;
    endfunction

    // receiver: random stall, except during the quiet stretch
    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < 21);
    end

    // result checker against the oldest expected distance
    always @(posedge i_clk) begin
        t_ray_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (dist_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_res);
            end else begin
                want = dist_expected.pop_front();
                if (o_res.distance !== want.distance ||
                        o_res.zero_direction !== want.zero_direction) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("distance exp %h/%b got %h/%b", want.distance,
                                 want.zero_direction, o_res.distance, o_res.zero_direction);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("point_to_ray_distance_unit: mismatch");
            $finish;
        end
    end

    // one request: random idle gap, then hold until accepted
    task automatic send_request(t_ray_req q);
        while (!quiet && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= q;
        do @(posedge i_clk); while (o_stall);
        dist_expected.push_back(predict_distance(q));
    endtask

    function automatic t_ray_req make_request(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
            logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
            logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        t_ray_req q;
        q = '{sx, sy, sz, dx, dy, dz, px, py, pz};
        return q;
    endfunction

    function automatic logic [31:0] rand_coord(int unsigned kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            2: return 32'($signed($urandom_range(65536 * 8)) - 65536 * 4);
            default: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    task automatic test_directed();
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
        localparam logic [31:0] MINV = 32'h8000_0000;
        // zero direction
        send_request(make_request(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
        send_request(make_request(MAXV, MINV, MAXV, 0, 0, 0, MINV, MAXV, MINV));
        // unit axes, distance one
        send_request(make_request(0, ONE, 0, ONE, 0, 0, 0, 0, 0));
        send_request(make_request(0, 0, 0, 0, ONE, 0, ONE, 0, 0));
        send_request(make_request(0, 0, 0, 0, 0, MINV, 0, ONE, 0));
        // point on the line
        send_request(make_request(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0));
        send_request(make_request(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MINV, MINV));
        // far away: distance at the 32-bit limit and saturation
        send_request(make_request(MAXV, 0, 0, 0, 0, 1, MINV, 0, 0));
        send_request(make_request(MAXV, MAXV, MAXV, 1, 0, 0, MINV, MINV, MINV));
        send_request(make_request(MINV, MINV, MINV, MAXV, MINV, MAXV, MAXV, MAXV, MAXV));
        send_request(make_request(MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV));
        // tiny direction, smallest steps, then start equal to point at extreme values
        send_request(make_request(1, 0, 0, 0, 1, 0, 0, 0, 0));
        send_request(make_request(32'hFFFF_FFFF, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0));
        send_request(make_request(3, 4, 0, 0, 0, 7, 0, 0, 0));
        send_request(make_request(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
        send_request(make_request(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
    endtask

    task automatic test_random(int unsigned count);
        t_ray_req    q;
        int unsigned kind;
        for (int unsigned n = 0; n < count; n++) begin
            quiet = (n >= count / 3 && n < count / 3 + 250);
            kind = $urandom_range(3);
            q = make_request(rand_coord(kind), rand_coord(kind), rand_coord(kind),
                             rand_coord($urandom_range(2)), rand_coord($urandom_range(2)),
                             rand_coord($urandom_range(2)),
                             rand_coord(kind), rand_coord(kind), rand_coord(kind));
            case ($urandom_range(9))
                0: {q.dir_x, q.dir_y, q.dir_z} = '0;
                1: {q.dir_y, q.dir_z} = '0;
                2: q.point_x = q.start_x + q.dir_x; // point x one direction step from start x
                default: ;
            endcase
            send_request(q);
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1930);
        i_valid <= 1'b0;
        while (dist_expected.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (mismatches == 0)
            $display("point_to_ray_distance_unit: match");
        else
            $display("point_to_ray_distance_unit: mismatch");
        $finish;
    end
endmodule
